### rtl/hhbp_pkg.sv
`default_nettype none

package hhbp_pkg;

  localparam int unsigned LimitWidth = 10;
  localparam int unsigned CountWidth = LimitWidth + 1;
  localparam logic [LimitWidth-1:0] LimitReset = 10'd255;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;

  localparam logic [3:0] CL_SKIP   = 4'd0;
  localparam logic [3:0] CL_KEY    = 4'd1;
  localparam logic [3:0] CL_COLON  = 4'd2;
  localparam logic [3:0] CL_SPACE  = 4'd3;
  localparam logic [3:0] CL_VALUE  = 4'd4;
  localparam logic [3:0] CL_CR     = 4'd5;
  localparam logic [3:0] CL_LF     = 4'd6;
  localparam logic [3:0] CL_END_CR = 4'd7;
  localparam logic [3:0] CL_END_LF = 4'd8;
  localparam logic [3:0] CL_ERROR  = 4'd9;
  localparam logic [3:0] CL_IDLE   = 4'd10;

  localparam logic FUNC_BYTE    = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  typedef enum logic [3:0] {
    ST_START  = 4'd0,
    ST_KEY    = 4'd1,
    ST_COLON  = 4'd2,
    ST_SPACE  = 4'd3,
    ST_VALUE  = 4'd4,
    ST_CR     = 4'd5,
    ST_LF     = 4'd6,
    ST_END_CR = 4'd7,
    ST_DONE   = 4'd8,
    ST_ERROR  = 4'd9
  } parser_state_t;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } hhbp_in_t;

  typedef struct packed {
    logic [7:0]            data_byte_out;
    logic [3:0]            byte_class;
    logic [LimitWidth-1:0] value_offset;
    logic                  header_done;
    logic                  parse_error;
  } hhbp_out_t;

  typedef struct packed {
    logic     valid;
    hhbp_in_t item;
  } hhbp_stage_t;

endpackage

`default_nettype wire

### rtl/hhbp_in_stage.sv
`default_nettype none

module hhbp_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire hhbp_pkg::hhbp_in_t in_item,
  input  wire logic              take,
  output hhbp_pkg::hhbp_stage_t  stage
);

  logic               valid_r, valid_nxt;
  hhbp_pkg::hhbp_in_t item_r;
  logic               load;

  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

`default_nettype wire

### rtl/hhbp_fsm.sv
`default_nettype none

module hhbp_fsm (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                take,
  input  wire hhbp_pkg::hhbp_in_t                  item,
  input  wire logic [hhbp_pkg::LimitWidth-1:0]     limit,
  output hhbp_pkg::hhbp_out_t                      result
);

  hhbp_pkg::parser_state_t state_r, state_nxt;
  logic [hhbp_pkg::CountWidth-1:0] count_r, count_nxt;
  logic [7:0] b;
  logic [3:0] cls;
  logic [hhbp_pkg::LimitWidth-1:0] off;

  assign b = item.data_byte;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    if (item.func == hhbp_pkg::FUNC_RESTART) begin
      state_nxt = hhbp_pkg::ST_START;
      count_nxt = '0;
    end else begin
      case (state_r)
        hhbp_pkg::ST_START: begin
          if (!(b inside {hhbp_pkg::CH_CR, hhbp_pkg::CH_LF})) state_nxt = hhbp_pkg::ST_KEY;
        end
        hhbp_pkg::ST_KEY: begin
          if (b == hhbp_pkg::CH_COLON) begin
            state_nxt = hhbp_pkg::ST_COLON;
          end else if (b inside {hhbp_pkg::CH_CR, hhbp_pkg::CH_LF}) begin
            state_nxt = hhbp_pkg::ST_ERROR;
          end
        end
        hhbp_pkg::ST_COLON: begin
          state_nxt = (b == hhbp_pkg::CH_SP) ? hhbp_pkg::ST_SPACE : hhbp_pkg::ST_ERROR;
        end
        hhbp_pkg::ST_SPACE: begin
          state_nxt = hhbp_pkg::ST_VALUE;
          count_nxt = hhbp_pkg::CountWidth'(1);
        end
        hhbp_pkg::ST_VALUE: begin
          if (b == hhbp_pkg::CH_CR) begin
            state_nxt = hhbp_pkg::ST_CR;
            count_nxt = '0;
          end else if (count_r > {1'b0, limit}) begin
            state_nxt = hhbp_pkg::ST_ERROR;
            count_nxt = '0;
          end else begin
            count_nxt = count_r + hhbp_pkg::CountWidth'(1);
          end
        end
        hhbp_pkg::ST_CR: begin
          state_nxt = (b == hhbp_pkg::CH_LF) ? hhbp_pkg::ST_LF : hhbp_pkg::ST_ERROR;
        end
        hhbp_pkg::ST_LF: begin
          state_nxt = (b == hhbp_pkg::CH_CR) ? hhbp_pkg::ST_END_CR : hhbp_pkg::ST_KEY;
        end
        hhbp_pkg::ST_END_CR: begin
          state_nxt = (b == hhbp_pkg::CH_LF) ? hhbp_pkg::ST_DONE : hhbp_pkg::ST_ERROR;
        end
        hhbp_pkg::ST_DONE, hhbp_pkg::ST_ERROR: begin
          state_nxt = state_r;
        end
        default: begin
          state_nxt = hhbp_pkg::ST_ERROR;
        end
      endcase
    end
  end

  always_comb begin
    cls = hhbp_pkg::CL_IDLE;
    off = '0;
    case (state_r)
      hhbp_pkg::ST_START: begin
        cls = (b inside {hhbp_pkg::CH_CR, hhbp_pkg::CH_LF}) ? hhbp_pkg::CL_SKIP : hhbp_pkg::CL_KEY;
      end
      hhbp_pkg::ST_KEY: begin
        if (b == hhbp_pkg::CH_COLON) begin
          cls = hhbp_pkg::CL_COLON;
        end else if (b inside {hhbp_pkg::CH_CR, hhbp_pkg::CH_LF}) begin
          cls = hhbp_pkg::CL_ERROR;
        end else begin
          cls = hhbp_pkg::CL_KEY;
        end
      end
      hhbp_pkg::ST_COLON: begin
        cls = (b == hhbp_pkg::CH_SP) ? hhbp_pkg::CL_SPACE : hhbp_pkg::CL_ERROR;
      end
      hhbp_pkg::ST_SPACE: begin
        cls = hhbp_pkg::CL_VALUE;
      end
      hhbp_pkg::ST_VALUE: begin
        if (b == hhbp_pkg::CH_CR) begin
          cls = hhbp_pkg::CL_CR;
        end else if (count_r > {1'b0, limit}) begin
          cls = hhbp_pkg::CL_ERROR;
        end else begin
          cls = hhbp_pkg::CL_VALUE;
          off = count_r[hhbp_pkg::LimitWidth-1:0];
        end
      end
      hhbp_pkg::ST_CR: begin
        cls = (b == hhbp_pkg::CH_LF) ? hhbp_pkg::CL_LF : hhbp_pkg::CL_ERROR;
      end
      hhbp_pkg::ST_LF: begin
        cls = (b == hhbp_pkg::CH_CR) ? hhbp_pkg::CL_END_CR : hhbp_pkg::CL_KEY;
      end
      hhbp_pkg::ST_END_CR: begin
        cls = (b == hhbp_pkg::CH_LF) ? hhbp_pkg::CL_END_LF : hhbp_pkg::CL_ERROR;
      end
      hhbp_pkg::ST_DONE, hhbp_pkg::ST_ERROR: begin
        cls = hhbp_pkg::CL_IDLE;
      end
      default: begin
        cls = hhbp_pkg::CL_ERROR;
      end
    endcase

    if (item.func == hhbp_pkg::FUNC_RESTART) begin
      result.data_byte_out = '0;
      result.byte_class    = hhbp_pkg::CL_IDLE;
      result.value_offset  = '0;
    end else begin
      result.data_byte_out = b;
      result.byte_class    = cls;
      result.value_offset  = off;
    end
    result.header_done = (state_nxt == hhbp_pkg::ST_DONE);
    result.parse_error = (state_nxt == hhbp_pkg::ST_ERROR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hhbp_pkg::ST_START;
      count_r <= '0;
    end else if (take) begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/hhbp_out_stage.sv
`default_nettype none

module hhbp_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire hhbp_pkg::hhbp_stage_t stage,
  input  wire hhbp_pkg::hhbp_out_t  result,
  output logic                      take,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output hhbp_pkg::hhbp_out_t       out_item
);

  logic                valid_r, valid_nxt;
  hhbp_pkg::hhbp_out_t item_r;

  assign take = stage.valid && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

`default_nettype wire

### rtl/http_header_byte_parser.sv
// HTTP header byte parser.
// Input channel in_valid / in_stall / in_item: one item per byte, func 0 for a
// header byte, func 1 to restart the parser for a new request.
// Result channel out_valid / out_stall / out_item: one result item per input
// item, in order, with the byte, its class, the value offset and the
// header_done / parse_error flags.
// Config port cfg_we / cfg_wdata writes value_length_limit; write it only
// while the block is idle.
// Path: an accepted item is held in the input register, then classified into
// the result register, which drives out_valid.
// Throughput: one item per cycle while the receiver does not stall; the parser
// state register updates as each item moves into the result register.
// Reset (rst_n low, synchronous): both stages empty, parser at start, value
// count zero, limit 255.
// Receiver stall: the result register holds its item; the input register
// holds one more, then in_stall rises until the result is taken.
`default_nettype none

module http_header_byte_parser (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire hhbp_pkg::hhbp_in_t              in_item,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output hhbp_pkg::hhbp_out_t                  out_item,
  input  wire logic                            cfg_we,
  input  wire logic [hhbp_pkg::LimitWidth-1:0] cfg_wdata
);

  logic [hhbp_pkg::LimitWidth-1:0] limit_r;
  hhbp_pkg::hhbp_stage_t           stage;
  hhbp_pkg::hhbp_out_t             result;
  logic                            take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= hhbp_pkg::LimitReset;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  hhbp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (take),
    .stage    (stage)
  );

  hhbp_fsm u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .item   (stage.item),
    .limit  (limit_r),
    .result (result)
  );

  hhbp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage),
    .result    (result),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

### rtl/hhbp_checker.sv
`default_nettype none

module hhbp_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire hhbp_pkg::hhbp_out_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_error_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.byte_class == hhbp_pkg::CL_ERROR) |-> out_item.parse_error)
    else $error("error class without parse_error");

  a_end_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.byte_class == hhbp_pkg::CL_END_LF) |-> out_item.header_done)
    else $error("end LF without header_done");

  a_offset_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.value_offset != '0) |-> out_item.byte_class == hhbp_pkg::CL_VALUE)
    else $error("nonzero offset outside a value");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.header_done && out_item.parse_error))
    else $error("done and error both set");

endmodule

bind http_header_byte_parser hhbp_checker u_hhbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire

### sim/http_header_byte_parser_test.sv
`timescale 1ns / 100ps

module http_header_byte_parser_test;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_stall;
  hhbp_pkg::hhbp_in_t                  in_item;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  hhbp_pkg::hhbp_out_t                 out_item;
  logic                                cfg_we;
  logic [hhbp_pkg::LimitWidth-1:0]     cfg_wdata;

  hhbp_pkg::parser_state_t             hdr_state = hhbp_pkg::ST_START;
  logic [hhbp_pkg::CountWidth-1:0]     hdr_count = '0;
  logic [hhbp_pkg::LimitWidth-1:0]     limit_setting = hhbp_pkg::LimitReset;
  hhbp_pkg::hhbp_out_t                 pending_results[$];
  int                                  mismatch_count = 0;
  int                                  items_sent = 0;
  int                                  burst_left = 0;
  int                                  stall_left = 0;
  int                                  stall_pct = 0;

  http_header_byte_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic hhbp_pkg::hhbp_out_t classify_byte(hhbp_pkg::hhbp_in_t item);
    hhbp_pkg::hhbp_out_t             res;
    logic [3:0]                      cls;
    logic [hhbp_pkg::LimitWidth-1:0] off;
    res = '0;
    if (item.func == hhbp_pkg::FUNC_RESTART) begin
      hdr_state = hhbp_pkg::ST_START;
      hdr_count = '0;
      res.byte_class = hhbp_pkg::CL_IDLE;
      return res;
    end
    cls = hhbp_pkg::CL_IDLE;
    off = '0;
    case (hdr_state)
      hhbp_pkg::ST_START: begin
        if (item.data_byte == hhbp_pkg::CH_CR || item.data_byte == hhbp_pkg::CH_LF) begin
          cls = hhbp_pkg::CL_SKIP;
        end else begin
          cls = hhbp_pkg::CL_KEY;
          hdr_state = hhbp_pkg::ST_KEY;
        end
      end
      hhbp_pkg::ST_KEY: begin
        if (item.data_byte == hhbp_pkg::CH_COLON) begin
          cls = hhbp_pkg::CL_COLON;
          hdr_state = hhbp_pkg::ST_COLON;
        end else if (item.data_byte == hhbp_pkg::CH_CR ||
                     item.data_byte == hhbp_pkg::CH_LF) begin
          cls = hhbp_pkg::CL_ERROR;
          hdr_state = hhbp_pkg::ST_ERROR;
        end else begin
          cls = hhbp_pkg::CL_KEY;
        end
      end
      hhbp_pkg::ST_COLON: begin
        if (item.data_byte == hhbp_pkg::CH_SP) begin
          cls = hhbp_pkg::CL_SPACE;
          hdr_state = hhbp_pkg::ST_SPACE;
        end else begin
          cls = hhbp_pkg::CL_ERROR;
          hdr_state = hhbp_pkg::ST_ERROR;
        end
      end
      hhbp_pkg::ST_SPACE: begin
        cls = hhbp_pkg::CL_VALUE;
        hdr_count = hhbp_pkg::CountWidth'(1);
        hdr_state = hhbp_pkg::ST_VALUE;
      end
      hhbp_pkg::ST_VALUE: begin
        if (item.data_byte == hhbp_pkg::CH_CR) begin
          cls = hhbp_pkg::CL_CR;
          hdr_count = '0;
          hdr_state = hhbp_pkg::ST_CR;
        end else if (hdr_count > {1'b0, limit_setting}) begin
          cls = hhbp_pkg::CL_ERROR;
          hdr_count = '0;
          hdr_state = hhbp_pkg::ST_ERROR;
        end else begin
          cls = hhbp_pkg::CL_VALUE;
          off = hdr_count[hhbp_pkg::LimitWidth-1:0];
          if (hdr_count < 1024) begin
            hdr_count = hdr_count + hhbp_pkg::CountWidth'(1);
          end
        end
      end
      hhbp_pkg::ST_CR: begin
        if (item.data_byte == hhbp_pkg::CH_LF) begin
          cls = hhbp_pkg::CL_LF;
          hdr_state = hhbp_pkg::ST_LF;
        end else begin
          cls = hhbp_pkg::CL_ERROR;
          hdr_state = hhbp_pkg::ST_ERROR;
        end
      end
      hhbp_pkg::ST_LF: begin
        if (item.data_byte == hhbp_pkg::CH_CR) begin
          cls = hhbp_pkg::CL_END_CR;
          hdr_state = hhbp_pkg::ST_END_CR;
        end else begin
          cls = hhbp_pkg::CL_KEY;
          hdr_state = hhbp_pkg::ST_KEY;
        end
      end
      hhbp_pkg::ST_END_CR: begin
        if (item.data_byte == hhbp_pkg::CH_LF) begin
          cls = hhbp_pkg::CL_END_LF;
          hdr_state = hhbp_pkg::ST_DONE;
        end else begin
          cls = hhbp_pkg::CL_ERROR;
          hdr_state = hhbp_pkg::ST_ERROR;
        end
      end
      hhbp_pkg::ST_DONE, hhbp_pkg::ST_ERROR: begin
        cls = hhbp_pkg::CL_IDLE;
      end
      default: begin
        cls = hhbp_pkg::CL_ERROR;
        hdr_state = hhbp_pkg::ST_ERROR;
      end
    endcase
    res.data_byte_out = item.data_byte;
    res.byte_class    = cls;
    res.value_offset  = off;
    res.header_done   = (hdr_state == hhbp_pkg::ST_DONE);
    res.parse_error   = (hdr_state == hhbp_pkg::ST_ERROR);
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic logic [7:0] other_byte(logic [7:0] skip_a, logic [7:0] skip_b,
                                            logic [7:0] skip_c);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == skip_a || b == skip_b || b == skip_c);
    return b;
  endfunction

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left <= $urandom_range(16, 200);
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 25;
        2: stall_pct <= 60;
        default: stall_pct <= 90;
      endcase
    end else begin
      stall_left <= stall_left - 1;
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    hhbp_pkg::hhbp_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing pending: byte %0d class %0d",
               out_item.data_byte_out, out_item.byte_class);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("data_byte_out", want.data_byte_out, out_item.data_byte_out);
        check_field("byte_class", want.byte_class, out_item.byte_class);
        check_field("value_offset", want.value_offset, out_item.value_offset);
        check_field("header_done", want.header_done, out_item.header_done);
        check_field("parse_error", want.parse_error, out_item.parse_error);
      end
    end
  end

  task automatic send_item(hhbp_pkg::hhbp_in_t item);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(classify_byte(item));
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    hhbp_pkg::hhbp_in_t item;
    item.func      = hhbp_pkg::FUNC_BYTE;
    item.data_byte = b;
    send_item(item);
  endtask

  task automatic send_restart();
    hhbp_pkg::hhbp_in_t item;
    item.func      = hhbp_pkg::FUNC_RESTART;
    item.data_byte = 8'($urandom_range(0, 255));
    send_item(item);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [hhbp_pkg::LimitWidth-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_setting = v;
  endtask

  task automatic send_request(int forced_len);
    logic [7:0] seq[$];
    int         val_len;
    int         pos;
    bit         first;
    first = 1'b1;
    repeat ($urandom_range(0, 2)) begin
      seq.push_back($urandom_range(0, 1) ? hhbp_pkg::CH_CR : hhbp_pkg::CH_LF);
    end
    repeat ($urandom_range(1, 4)) begin
      repeat ($urandom_range(1, 6)) begin
        seq.push_back(other_byte(hhbp_pkg::CH_CR, hhbp_pkg::CH_LF, hhbp_pkg::CH_COLON));
      end
      seq.push_back(hhbp_pkg::CH_COLON);
      seq.push_back(hhbp_pkg::CH_SP);
      if (first && forced_len >= 0) begin
        val_len = forced_len;
      end else if (limit_setting <= 30 && $urandom_range(0, 9) >= 6) begin
        val_len = int'(limit_setting) + int'($urandom_range(0, 2));
      end else begin
        val_len = $urandom_range(1, 8);
      end
      first = 1'b0;
      repeat (val_len) begin
        seq.push_back(other_byte(hhbp_pkg::CH_CR, hhbp_pkg::CH_CR, hhbp_pkg::CH_CR));
      end
      seq.push_back(hhbp_pkg::CH_CR);
      seq.push_back(hhbp_pkg::CH_LF);
    end
    seq.push_back(hhbp_pkg::CH_CR);
    seq.push_back(hhbp_pkg::CH_LF);
    repeat ($urandom_range(0, 2)) seq.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 4) == 0) begin
      pos = $urandom_range(0, seq.size() - 1);
      case ($urandom_range(0, 4))
        0: seq[pos] = hhbp_pkg::CH_CR;
        1: seq[pos] = hhbp_pkg::CH_LF;
        2: seq[pos] = hhbp_pkg::CH_COLON;
        3: seq[pos] = hhbp_pkg::CH_SP;
        default: seq[pos] = 8'($urandom_range(0, 255));
      endcase
    end
    send_restart();
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic send_noise();
    hhbp_pkg::hhbp_in_t item;
    send_restart();
    repeat ($urandom_range(4, 16)) begin
      item.func = ($urandom_range(0, 9) == 0) ? hhbp_pkg::FUNC_RESTART : hhbp_pkg::FUNC_BYTE;
      case ($urandom_range(0, 5))
        0: item.data_byte = hhbp_pkg::CH_CR;
        1: item.data_byte = hhbp_pkg::CH_LF;
        2: item.data_byte = hhbp_pkg::CH_COLON;
        3: item.data_byte = hhbp_pkg::CH_SP;
        default: item.data_byte = 8'($urandom_range(0, 255));
      endcase
      send_item(item);
    end
  endtask

  // skip bytes, colon and LF as key starts, CR as first value byte, end, idle
  task automatic test_header_walk();
    send_restart();
    send_byte(hhbp_pkg::CH_LF);
    send_byte(hhbp_pkg::CH_CR);
    send_byte(hhbp_pkg::CH_COLON);
    send_byte(8'hFF);
    send_byte(hhbp_pkg::CH_COLON);
    send_byte(hhbp_pkg::CH_SP);
    send_byte(hhbp_pkg::CH_CR);
    send_byte(8'h00);
    send_byte(hhbp_pkg::CH_CR);
    send_byte(hhbp_pkg::CH_LF);
    send_byte(hhbp_pkg::CH_LF);
    send_byte(hhbp_pkg::CH_COLON);
    send_byte(hhbp_pkg::CH_SP);
    send_byte(8'h76);
    send_byte(hhbp_pkg::CH_CR);
    send_byte(hhbp_pkg::CH_LF);
    send_byte(hhbp_pkg::CH_CR);
    send_byte(hhbp_pkg::CH_LF);
    send_byte(8'h7A);
  endtask

  task automatic test_error_idle();
    send_restart();
    send_byte(8'h6B);
    send_byte(hhbp_pkg::CH_CR);
    send_byte(8'h71);
  endtask

  task automatic test_limit_zero();
    drain_results();
    write_limit('0);
    send_restart();
    send_byte(8'h6B);
    send_byte(hhbp_pkg::CH_COLON);
    send_byte(hhbp_pkg::CH_SP);
    send_byte(8'h61);
    send_byte(8'h62);
    send_byte(8'h63);
  endtask

  task automatic test_random_traffic();
    logic [hhbp_pkg::LimitWidth-1:0] limits[6];
    int                              target;
    limits = '{hhbp_pkg::LimitReset, 10'd1023, 10'd0, 10'd1, 10'd3, 10'd12};
    limits[5] = hhbp_pkg::LimitWidth'($urandom_range(2, 30));
    foreach (limits[p]) begin
      drain_results();
      write_limit(limits[p]);
      if (limits[p] == 10'd1023) begin
        send_request(1025);
      end
      target = items_sent + 130;
      while (items_sent < target) begin
        if ($urandom_range(0, 9) == 0) begin
          send_noise();
        end else begin
          send_request(-1);
        end
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_header_walk();
    test_error_idle();
    test_limit_zero();
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### http_header_byte_parser.f
rtl/hhbp_pkg.sv
rtl/hhbp_in_stage.sv
rtl/hhbp_fsm.sv
rtl/hhbp_out_stage.sv
rtl/http_header_byte_parser.sv
rtl/hhbp_checker.sv
sim/http_header_byte_parser_test.sv
